@@ rtl/core/ralloc_pkg.sv @@
// ----------------------------------------------------------------------------
// ralloc_pkg
// Shared types and codes of the range bitmap identifier allocator.
// ----------------------------------------------------------------------------
package ralloc_pkg;

  // Field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned BASE_W   = 15;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 15;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLAIM_ID  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLAIM_ANY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd3;

  // Configuration register indexes
  localparam logic REG_BASE_ID     = 1'b0;
  localparam logic REG_ENTRY_COUNT = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [ID_W-1:0]  id_in;
  } ralloc_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id_out;
    logic [CNT_W-1:0]    free_left;
  } ralloc_out_t;

endpackage

@@ rtl/core/ralloc_ram.sv @@
// ----------------------------------------------------------------------------
// ralloc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ralloc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/ralloc_ffz.sv @@
// ----------------------------------------------------------------------------
// ralloc_ffz
// Find-first-zero encoder: lowest index of a clear bit in a vector.
// ----------------------------------------------------------------------------
module ralloc_ffz #(
  parameter int unsigned WIDTH = 32
) (
  input  logic [WIDTH-1:0]                         vec_i,
  output logic                                     found_o,
  output logic [(WIDTH > 1 ? $clog2(WIDTH) : 1)-1:0] idx_o
);

  localparam int unsigned IW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  // Priority scan, lowest index wins
  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (!vec_i[i]) begin
        found_o = 1'b1;
        idx_o   = IW'(i);
      end
    end
  end

endmodule

@@ rtl/core/range_bitmap_allocator_top.sv @@
// A command's mark row is read when it is accepted; the read-modify-write
// back into the mark RAM and the result register follow once a result can
// be taken. No new command is accepted until the last one has executed.
// Reset and configuration writes clear the per-row valid and full flags at
// once; no clearing pass runs over the mark RAM.
// ----------------------------------------------------------------------------
// range_bitmap_allocator_top
// First-fit identifier allocator over [base_id, base_id + entry_count).
// Used marks live in a RAM of rows; per-row valid and full flags steer the
// search for the lowest free entry.
// ----------------------------------------------------------------------------
module range_bitmap_allocator_top #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Command channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ralloc_pkg::ralloc_in_t        in_data_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ralloc_pkg::ralloc_out_t       out_data_o,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [ralloc_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int unsigned WORD_W = (ENTRIES < 32) ? ENTRIES : 32;
  localparam int unsigned ROWS   = (ENTRIES + WORD_W - 1) / WORD_W;
  localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned BIT_W  = (WORD_W > 1) ? $clog2(WORD_W) : 1;
  localparam int unsigned CNT_W  = ralloc_pkg::CNT_W;
  localparam int unsigned ID_W   = ralloc_pkg::ID_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                                state_q, state_d;
  logic [ralloc_pkg::BASE_W-1:0]       base_q;
  logic [CNT_W-1:0]                    entry_count_q;
  logic [CNT_W-1:0]                    free_total_q;
  logic [ROWS-1:0]                     row_valid_q;
  logic [ROWS-1:0]                     row_full_q;
  logic                                out_valid_q;
  ralloc_pkg::ralloc_out_t             out_q;

  logic [ralloc_pkg::CMD_W-1:0]        cmd_q;
  logic                                in_range_q;
  logic [ROW_AW-1:0]                   row_q;
  logic [BIT_W-1:0]                    bit_q;

  // Effective entry count: min(entry_count, ENTRIES)
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
    logic [10:0] lim;
    lim = 11'(ENTRIES);
    return ({4'b0, cnt} < lim) ? cnt : CNT_W'(ENTRIES);
  endfunction

  logic [CNT_W-1:0] n_eff;
  assign n_eff = eff_count(entry_count_q);

  // Accept side
  logic in_fire;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;

  // Locate the requested identifier in the range
  logic [ID_W:0]     diff;
  logic [ID_W-1:0]   idx_w;
  logic              loc_in_range;
  logic [ROW_AW-1:0] loc_row;
  logic [BIT_W-1:0]  loc_bit;

  assign diff         = {1'b0, in_data_i.id_in} - {2'b0, base_q};
  assign loc_in_range = !diff[ID_W] && (diff[ID_W-1:0] < {9'b0, n_eff});
  assign idx_w        = {9'b0, diff[CNT_W-1:0]};
  assign loc_row      = ROW_AW'(idx_w >> BIT_W);
  assign loc_bit      = BIT_W'(idx_w);

  // Lowest row that still has a clear mark
  logic              row_found;
  logic [ROW_AW-1:0] any_row;

  ralloc_ffz #(.WIDTH(ROWS)) u_row_ffz (
    .vec_i  (row_full_q),
    .found_o(row_found),
    .idx_o  (any_row)
  );

  // Mark RAM
  logic              ram_we;
  logic [ROW_AW-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] new_word;

  assign ram_raddr = (in_data_i.command == ralloc_pkg::CMD_CLAIM_ANY) ? any_row : loc_row;

  ralloc_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_mark_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(row_q),
    .wdata_i(new_word),
    .re_i   (in_fire),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Execute side: the row as it stands, invalid rows read as all free
  logic [WORD_W-1:0] cur_word;
  logic              bit_found;
  logic [BIT_W-1:0]  any_bit;
  logic              exec_go;

  assign cur_word = row_valid_q[row_q] ? ram_rdata : '0;
  assign exec_go  = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  ralloc_ffz #(.WIDTH(WORD_W)) u_bit_ffz (
    .vec_i  (cur_word),
    .found_o(bit_found),
    .idx_o  (any_bit)
  );

  logic [ralloc_pkg::STATUS_W-1:0] status;
  logic [ID_W-1:0]                 grant;
  logic [ID_W-1:0]                 grant_idx;
  logic [CNT_W-1:0]                free_d;
  logic                            modify;

  assign grant_idx = (ID_W'(row_q) << BIT_W) | ID_W'(any_bit);

  // Command decode and mark update
  always_comb begin
    status   = ralloc_pkg::ST_RANGE;
    grant    = '0;
    free_d   = free_total_q;
    modify   = 1'b0;
    new_word = cur_word;
    case (cmd_q)
      ralloc_pkg::CMD_CLAIM_ID: begin
        if (!in_range_q) begin
          status = ralloc_pkg::ST_RANGE;
        end else if (cur_word[bit_q]) begin
          status = ralloc_pkg::ST_BUSY;
        end else begin
          status          = ralloc_pkg::ST_OK;
          new_word[bit_q] = 1'b1;
          free_d          = free_total_q - CNT_W'(1);
          modify          = 1'b1;
        end
      end
      ralloc_pkg::CMD_CLAIM_ANY: begin
        if (free_total_q == '0 || !row_found || !bit_found) begin
          status = ralloc_pkg::ST_NOSPACE;
        end else begin
          status            = ralloc_pkg::ST_OK;
          new_word[any_bit] = 1'b1;
          free_d            = free_total_q - CNT_W'(1);
          grant             = ID_W'({1'b0, base_q} + grant_idx);
          modify            = 1'b1;
        end
      end
      ralloc_pkg::CMD_RELEASE: begin
        if (!in_range_q) begin
          status = ralloc_pkg::ST_RANGE;
        end else if (!cur_word[bit_q]) begin
          status = ralloc_pkg::ST_BUSY;
        end else begin
          status          = ralloc_pkg::ST_OK;
          new_word[bit_q] = 1'b0;
          free_d          = free_total_q + CNT_W'(1);
          modify          = 1'b1;
        end
      end
      default: begin
        status = ralloc_pkg::ST_RANGE;
      end
    endcase
  end

  assign ram_we = exec_go && modify;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state, configuration and allocation bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      base_q        <= '0;
      entry_count_q <= CNT_W'(64);
      free_total_q  <= eff_count(CNT_W'(64));
      row_valid_q   <= '0;
      row_full_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        row_valid_q <= '0;
        row_full_q  <= '0;
        if (cfg_idx_i == ralloc_pkg::REG_BASE_ID) begin
          base_q       <= cfg_data_i[ralloc_pkg::BASE_W-1:0];
          free_total_q <= n_eff;
        end else begin
          entry_count_q <= cfg_data_i[CNT_W-1:0];
          free_total_q  <= eff_count(cfg_data_i[CNT_W-1:0]);
        end
      end else if (exec_go) begin
        free_total_q <= free_d;
        if (modify) begin
          row_valid_q[row_q] <= 1'b1;
          row_full_q[row_q]  <= &new_word;
        end
      end
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Command capture and result register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q      <= in_data_i.command;
      in_range_q <= loc_in_range;
      row_q      <= ram_raddr;
      bit_q      <= loc_bit;
    end
    if (exec_go) begin
      out_q.status    <= status;
      out_q.id_out    <= grant;
      out_q.free_left <= free_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/core/ralloc_checker.sv @@
// ----------------------------------------------------------------------------
// ralloc_checker
// Port-level checks of the range bitmap allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ralloc_checker #(
  parameter int unsigned ENTRIES = 64
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input ralloc_pkg::ralloc_out_t out_data_o
);

  // Free count never exceeds the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({4'b0, out_data_o.free_left} <= 11'(ENTRIES)))
    else $error("free count above store depth");

  // A granted identifier only comes with an ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.id_out != '0) |-> (out_data_o.status == ralloc_pkg::ST_OK))
    else $error("identifier returned without ok status");

  // No free entry means the free count is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ralloc_pkg::ST_NOSPACE)
      |-> (out_data_o.free_left == '0))
    else $error("no space reported with free entries left");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind range_bitmap_allocator_top ralloc_checker #(.ENTRIES(ENTRIES)) u_ralloc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
